// File: sv/row_extreme_select_mask_defines.svh
// Assertion macros for the row extreme select mask block.
// Included by the RTL files that carry concurrent assertions.
`ifndef ROW_EXTREME_SELECT_MASK_DEFINES_SVH
`define ROW_EXTREME_SELECT_MASK_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define RXSM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rxsm assertion failed");

// next-cycle implication, disabled while reset is active
`define RXSM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rxsm assertion failed");

`endif

// File: sv/rxsm_pkg.sv
// Shared types, constants and functions of the row extreme select mask block.
// No dependencies.
`default_nettype none

package rxsm_pkg;

	localparam int MAX_ROW = 64;

	localparam logic [31:0] ONE_F32_BITS = 32'h3F80_0000;

	localparam logic [1:0] REG_ROW_LENGTH    = 2'd0;
	localparam logic [1:0] REG_SELECT_MIN    = 2'd1;
	localparam logic [1:0] REG_GRADIENT_MODE = 2'd2;

	typedef struct packed {
		logic [6:0] row_length;
		logic       select_min;
		logic       gradient_mode;
	} cfg_t;

	typedef struct packed {
		logic [31:0] best_bits;
		logic [5:0]  best_pos;
		logic [6:0]  count;
		logic        gradient;
	} row_desc_t;

	function automatic logic [31:0] order_key(input logic [31:0] bits);
		logic [31:0] key;
		if (bits[31]) begin
			key = ~bits;
		end else begin
			key = bits | 32'h8000_0000;
		end
		return key;
	endfunction

endpackage

`default_nettype wire

// File: sv/rxsm_front.sv
// Front end: accepts samples, tracks the row extreme and closes rows.
// Depends on rxsm_pkg.
`default_nettype none

module rxsm_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire  [31:0]             sample_bits,
	input  wire                     tensor_end,
	input  rxsm_pkg::cfg_t          cfg,
	input  wire                     q_full,
	output logic                    push,
	output rxsm_pkg::row_desc_t     push_desc
);
	import rxsm_pkg::*;

	logic [6:0]  seen_q;
	logic [31:0] best_bits_q;
	logic [5:0]  best_pos_q;

	logic        accept;
	logic        better;
	logic [6:0]  next_seen;
	logic [6:0]  eff_len;
	logic        close;
	logic [31:0] new_best;
	logic [5:0]  new_pos;
	logic [31:0] key_s;
	logic [31:0] key_b;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		key_s = order_key(sample_bits);
		key_b = order_key(best_bits_q);
		better = cfg.select_min ? (key_s < key_b) : (key_s > key_b);
		if (seen_q == 7'd0) begin
			new_best = sample_bits;
			new_pos  = 6'd0;
		end else if (better) begin
			new_best = sample_bits;
			new_pos  = seen_q[5:0];
		end else begin
			new_best = best_bits_q;
			new_pos  = best_pos_q;
		end
		if (cfg.row_length == 7'd0) begin
			eff_len = 7'd1;
		end else if (cfg.row_length > 7'(MAX_ROW)) begin
			eff_len = 7'(MAX_ROW);
		end else begin
			eff_len = cfg.row_length;
		end
		next_seen = seen_q + 7'd1;
		close     = tensor_end || (next_seen >= eff_len);
	end

	assign push                = accept && close;
	assign push_desc.best_bits = new_best;
	assign push_desc.best_pos  = new_pos;
	assign push_desc.count     = next_seen;
	assign push_desc.gradient  = cfg.gradient_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			best_bits_q <= '0;
			best_pos_q  <= '0;
		end else if (accept) begin
			seen_q      <= close ? 7'd0 : next_seen;
			best_bits_q <= new_best;
			best_pos_q  <= new_pos;
		end
	end

endmodule

`default_nettype wire

// File: sv/rxsm_queue.sv
// Row descriptor queue between the front and back ends.
// Depends on rxsm_pkg and the assertion macro header.
`default_nettype none
`include "row_extreme_select_mask_defines.svh"

module rxsm_queue #(
	parameter int DEPTH = 2
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  rxsm_pkg::row_desc_t     push_desc,
	output logic                    full,
	input  wire                     pop,
	output rxsm_pkg::row_desc_t     pop_desc,
	output logic                    not_empty
);
	import rxsm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	row_desc_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PW'(1);
		end
		return n;
	endfunction

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`RXSM_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)
	`RXSM_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, not_empty)

endmodule

`default_nettype wire

// File: sv/rxsm_back.sv
// Back end: expands one row descriptor into a run of mask results.
// Depends on rxsm_pkg and the assertion macro header.
`default_nettype none
`include "row_extreme_select_mask_defines.svh"

module rxsm_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     q_valid,
	input  rxsm_pkg::row_desc_t     q_desc,
	output logic                    pop,
	output logic                    out_valid,
	input  wire                     out_ready,
	output logic [31:0]             result_bits,
	output logic                    run_last
);
	import rxsm_pkg::*;

	logic        active_q;
	row_desc_t   desc_q;
	logic [5:0]  idx_q;

	logic        transfer;

	assign out_valid = active_q;
	assign transfer  = out_valid && out_ready;
	assign run_last  = ({1'b0, idx_q} + 7'd1) == desc_q.count;
	assign pop       = q_valid && (!active_q || (transfer && run_last));

	always_comb begin
		if (idx_q == desc_q.best_pos) begin
			result_bits = desc_q.gradient ? ONE_F32_BITS : desc_q.best_bits;
		end else begin
			result_bits = 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= q_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (transfer) begin
			if (run_last) begin
				active_q <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 6'd1;
			end
		end
	end

	`RXSM_ASSERT_IMP(a_idx_in_run, clk, arst_n, active_q, {1'b0, idx_q} < desc_q.count)
	`RXSM_ASSERT_NXT(a_hold_stalled, clk, arst_n, active_q && !out_ready, $stable(idx_q) && active_q)

endmodule

`default_nettype wire

// File: sv/row_extreme_select_mask.sv
// Row extreme select mask: one sample per cycle in, one mask result per cycle out.
// A row's closing sample writes its descriptor into the queue; an idle back end
// loads it and raises out_valid; a result is held while out_ready is low.
// Throughput: 1 sample per cycle; a row of N samples drains as N results, 1 per cycle.
// The descriptor queue between the compare front end and the run back end sets the
// slack; the front stalls only while the queue is full.
// Reset: registers return to row_length 64, max mode, forward mode; counters clear.
`default_nettype none

module row_extreme_select_mask #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_ready,
	input  wire  [31:0]  sample_bits,
	input  wire          tensor_end,
	output logic         out_valid,
	input  wire          out_ready,
	output logic [31:0]  result_bits,
	output logic         run_last,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [3:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import rxsm_pkg::*;

	cfg_t       cfg_q;
	row_desc_t  push_desc;
	row_desc_t  pop_desc;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_valid;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_length    <= 7'd64;
			cfg_q.select_min    <= 1'b0;
			cfg_q.gradient_mode <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_ROW_LENGTH:    cfg_q.row_length    <= pwdata[6:0];
				REG_SELECT_MIN:    cfg_q.select_min    <= pwdata[0];
				REG_GRADIENT_MODE: cfg_q.gradient_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROW_LENGTH:    prdata = {25'd0, cfg_q.row_length};
			REG_SELECT_MIN:    prdata = {31'd0, cfg_q.select_min};
			REG_GRADIENT_MODE: prdata = {31'd0, cfg_q.gradient_mode};
			default:           prdata = 32'd0;
		endcase
	end

	rxsm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_bits (sample_bits),
		.tensor_end  (tensor_end),
		.cfg         (cfg_q),
		.q_full      (q_full),
		.push        (push),
		.push_desc   (push_desc)
	);

	rxsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.not_empty (q_valid)
	);

	rxsm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_desc      (pop_desc),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_bits (result_bits),
		.run_last    (run_last)
	);

endmodule

`default_nettype wire
